>>> sv/bcq_pkg.sv
// ----------------------------------------------------------------------------
// bcq_pkg - shared types and constants for the biquad cascade
// Widths, coefficient slot codes, register indexes and the structs that run
// between the section cells and the top level.
// ----------------------------------------------------------------------------
package bcq_pkg;

    localparam int NUM_SECTIONS = 2;
    localparam int NUM_SLOTS    = 5;

    localparam int SAMPLE_W = 16;
    localparam int SIG_W    = 32;   // Q16.16 section signals
    localparam int COEF_W   = 24;   // Q2.22 coefficients
    localparam int SLOT_W   = 3;
    localparam int SEC_W    = 4;
    localparam int PROD_W   = SIG_W + COEF_W;
    localparam int ACC_W    = PROD_W + 3;   // five products summed
    localparam int COEF_FRAC = 22;
    localparam int SIG_FRAC  = 16;

    localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_DRAIN = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_DONE  = 3'd6;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    localparam logic REG_OUT_MIN = 1'b0;
    localparam logic REG_OUT_MAX = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] OUT_MIN_RST = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX_RST = 16'sh7fff;

    // one signal value handed from cell to cell
    typedef struct packed {
        logic                    vld;
        logic signed [SIG_W-1:0] data;
    } t_link;

    // coefficient write broadcast to a cell
    typedef struct packed {
        logic                     we;
        logic [SLOT_W-1:0]        slot;
        logic signed [COEF_W-1:0] value;
    } t_coef_wr;

endpackage

>>> sv/bcq_cell.sv
// ----------------------------------------------------------------------------
// bcq_cell - one direct-form-I biquad section
// Holds its five coefficients and x1/x2/y1/y2 history. A value on the input
// link runs through one multiplier over five steps; the rounded, saturated
// result leaves on the output link once the step counter reaches its done step.
// ----------------------------------------------------------------------------
module bcq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcq_pkg::t_coef_wr i_cw,
    input  bcq_pkg::t_link    i_link,
    output bcq_pkg::t_link    o_link
);

    localparam int SIG_W  = bcq_pkg::SIG_W;
    localparam int COEF_W = bcq_pkg::COEF_W;
    localparam int PROD_W = bcq_pkg::PROD_W;
    localparam int ACC_W  = bcq_pkg::ACC_W;
    localparam int RND_W  = ACC_W - bcq_pkg::COEF_FRAC;

    logic signed [COEF_W-1:0] r_coef [bcq_pkg::NUM_SLOTS];
    logic signed [SIG_W-1:0]  r_x0, r_x1, r_x2, r_y1, r_y2;
    logic [bcq_pkg::SLOT_W-1:0] r_step;
    logic                     r_act;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pvld;
    logic                     r_psub;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_vld;
    logic signed [SIG_W-1:0]  r_y;

    logic signed [SIG_W-1:0]  w_opnd;
    logic signed [COEF_W-1:0] w_coef;
    logic                     w_mul;
    logic signed [ACC_W-1:0]  w_rnd_sum;
    logic signed [RND_W-1:0]  w_rnd;
    logic signed [SIG_W-1:0]  w_sat;

    always_comb begin
        w_opnd = r_x0;
        w_coef = r_coef[0];
        unique case (r_step)
            bcq_pkg::SLOT_B0: begin w_opnd = r_x0; w_coef = r_coef[0]; end
            bcq_pkg::SLOT_B1: begin w_opnd = r_x1; w_coef = r_coef[1]; end
            bcq_pkg::SLOT_B2: begin w_opnd = r_x2; w_coef = r_coef[2]; end
            bcq_pkg::SLOT_A1: begin w_opnd = r_y1; w_coef = r_coef[3]; end
            bcq_pkg::SLOT_A2: begin w_opnd = r_y2; w_coef = r_coef[4]; end
            default: begin w_opnd = r_x0; w_coef = r_coef[0]; end
        endcase
    end

    assign w_mul = r_act && (r_step <= bcq_pkg::SLOT_A2);

    // round half up to Q16.16, then clamp to 32 bits
    assign w_rnd_sum = r_acc + (ACC_W'(1) <<< (bcq_pkg::COEF_FRAC - 1));
    assign w_rnd     = w_rnd_sum[ACC_W-1:bcq_pkg::COEF_FRAC];

    always_comb begin
        if (w_rnd > RND_W'(signed'({1'b0, {(SIG_W-1){1'b1}}}))) begin
            w_sat = {1'b0, {(SIG_W-1){1'b1}}};
        end else if (w_rnd < RND_W'(signed'({1'b1, {(SIG_W-1){1'b0}}}))) begin
            w_sat = {1'b1, {(SIG_W-1){1'b0}}};
        end else begin
            w_sat = w_rnd[SIG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_step    <= '0;
            r_pvld    <= 1'b0;
            r_out_vld <= 1'b0;
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
            for (int k = 0; k < bcq_pkg::NUM_SLOTS; k++) begin
                r_coef[k] <= '0;
            end
        end else begin
            r_out_vld <= 1'b0;
            r_pvld    <= w_mul;
            if (i_cw.we) begin
                for (int k = 0; k < bcq_pkg::NUM_SLOTS; k++) begin
                    if (i_cw.slot == bcq_pkg::SLOT_W'(k)) begin
                        r_coef[k] <= i_cw.value;
                    end
                end
            end
            if (i_link.vld) begin
                r_act  <= 1'b1;
                r_step <= bcq_pkg::SLOT_B0;
            end else if (r_act) begin
                if (r_step == bcq_pkg::SLOT_DONE) begin
                    r_act     <= 1'b0;
                    r_out_vld <= 1'b1;
                    r_x2 <= r_x1;
                    r_x1 <= r_x0;
                    r_y2 <= r_y1;
                    r_y1 <= w_sat;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_link.vld) begin
            r_x0  <= i_link.data;
            r_acc <= '0;
        end else if (r_pvld) begin
            if (r_psub) begin
                r_acc <= r_acc - ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        r_prod <= w_opnd * w_coef;
        r_psub <= (r_step >= bcq_pkg::SLOT_A1);
        if (r_act && r_step == bcq_pkg::SLOT_DONE) begin
            r_y <= w_sat;
        end
    end

    assign o_link.vld  = r_out_vld;
    assign o_link.data = r_y;

endmodule

>>> sv/biquad_cascade_iir_filter.sv
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter - cascaded direct-form-I biquad IIR filter
// A chain of section cells filters one 16-bit sample per item; the final
// Q16.16 value is rounded and clipped to the out_min/out_max registers.
//
//   channel | handshake                 | payload
//   --------+---------------------------+----------------------------------
//   in      | i_in_valid / o_in_stall   | i_op, i_sample_in, i_coef_section,
//           |                           | i_coef_slot, i_coef_value
//   out     | o_out_valid / i_out_stall | o_sample_out, o_clipped
//   cfg     | APB psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// A filter item holds the input stalled from its accepting edge until its
// result moves into the output register: each cell runs its five products
// through one multiplier over its steps, the links between cells add no
// register, then come the final register r_fin and the output register.
// A coefficient write yields no item and does not stall the input.
// Reset is synchronous, active low; it clears coefficients and history.
// The next item is taken while a result waits in the output register; a
// second result waits in r_fin and stalls the input until the output drains.
// ----------------------------------------------------------------------------
module biquad_cascade_iir_filter #(
    parameter int NUM_SECTIONS = bcq_pkg::NUM_SECTIONS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic signed [15:0] i_sample_in,
    input  logic [3:0]  i_coef_section,
    input  logic [2:0]  i_coef_slot,
    input  logic signed [23:0] i_coef_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [15:0] o_sample_out,
    output logic        o_clipped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SIG_W = bcq_pkg::SIG_W;
    localparam int SAMPLE_W = bcq_pkg::SAMPLE_W;
    localparam int FRAC = bcq_pkg::SIG_FRAC;
    localparam int RW = SIG_W + 1 - FRAC;

    logic signed [SAMPLE_W-1:0] r_out_min, r_out_max;
    logic                       r_busy;
    logic                       r_fin_vld;
    logic signed [SIG_W-1:0]    r_fin;
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic                       r_clipped;

    logic                       w_acc;
    logic                       w_sec_ok;
    logic                       w_cfg_wr;
    logic                       w_reg_idx;
    logic                       w_out_load;
    logic signed [SIG_W:0]      w_fin_sum;
    logic signed [RW-1:0]       w_fin_rnd;
    logic signed [SAMPLE_W-1:0] w_y;
    logic                       w_clip;

    bcq_pkg::t_link    w_link [NUM_SECTIONS+1];
    bcq_pkg::t_coef_wr w_cw   [NUM_SECTIONS];

    assign o_in_stall = r_busy;
    assign w_acc      = i_in_valid && !r_busy;
    assign w_sec_ok   = ({1'b0, i_coef_section} < 5'(NUM_SECTIONS))
                        && (i_coef_slot <= bcq_pkg::SLOT_A2);

    assign w_link[0].vld  = w_acc && (i_op == bcq_pkg::OP_FILTER);
    assign w_link[0].data = {i_sample_in, {FRAC{1'b0}}};

    for (genvar g = 0; g < NUM_SECTIONS; g++) begin : g_cell
        assign w_cw[g].we    = w_acc && (i_op == bcq_pkg::OP_COEF) && w_sec_ok
                               && (i_coef_section == 4'(g));
        assign w_cw[g].slot  = i_coef_slot;
        assign w_cw[g].value = i_coef_value;

        bcq_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cw   (w_cw[g]),
            .i_link (w_link[g]),
            .o_link (w_link[g+1])
        );
    end

    // final rounding to integer and clipping
    assign w_fin_sum = (SIG_W + 1)'(r_fin) + (SIG_W + 1)'(1 << (FRAC - 1));
    assign w_fin_rnd = w_fin_sum[SIG_W:FRAC];

    always_comb begin
        w_y    = w_fin_rnd[SAMPLE_W-1:0];
        w_clip = 1'b0;
        priority if (w_fin_rnd < RW'(r_out_min)) begin
            w_y    = r_out_min;
            w_clip = 1'b1;
        end else if (w_fin_rnd > RW'(r_out_max)) begin
            w_y    = r_out_max;
            w_clip = 1'b1;
        end else begin
            w_y    = w_fin_rnd[SAMPLE_W-1:0];
            w_clip = 1'b0;
        end
    end

    assign w_out_load = r_fin_vld && (!r_out_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_fin_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_link[0].vld) begin
                r_busy <= 1'b1;
            end else if (w_out_load) begin
                r_busy <= 1'b0;
            end
            if (w_link[NUM_SECTIONS].vld) begin
                r_fin_vld <= 1'b1;
            end else if (w_out_load) begin
                r_fin_vld <= 1'b0;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_link[NUM_SECTIONS].vld) begin
            r_fin <= w_link[NUM_SECTIONS].data;
        end
        if (w_out_load) begin
            r_sample_out <= w_y;
            r_clipped    <= w_clip;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

    // configuration registers
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_min <= bcq_pkg::OUT_MIN_RST;
            r_out_max <= bcq_pkg::OUT_MAX_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                bcq_pkg::REG_OUT_MIN: r_out_min <= pwdata[SAMPLE_W-1:0];
                bcq_pkg::REG_OUT_MAX: r_out_max <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            bcq_pkg::REG_OUT_MIN: prdata = 32'(r_out_min);
            bcq_pkg::REG_OUT_MAX: prdata = 32'(r_out_max);
            default:              prdata = '0;
        endcase
    end

endmodule

>>> sv/bcq_checker.sv
// ----------------------------------------------------------------------------
// bcq_checker - port-level checks for the biquad cascade
// Watches the handshakes and the item flow seen at the top level's ports.
// ----------------------------------------------------------------------------
module bcq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_op,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_sample_out,
    input logic        o_clipped,
    input logic        pready
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out)
            && $stable(o_clipped))
        else $error("stalled result changed or dropped");

    // a filter item keeps the input side busy while the chain runs
    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_op |=> o_in_stall)
        else $error("input taken while a sample is in the chain");

    // a coefficient write never occupies the chain
    a_coef_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_op |=> !o_in_stall)
        else $error("coefficient write stalled the input");

    // no result appears out of an idle chain
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall && !o_out_valid && !(i_in_valid && !i_op) |=> !o_out_valid)
        else $error("result without a filter item");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind biquad_cascade_iir_filter bcq_checker u_bcq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_op        (i_op),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_sample_out(o_sample_out),
    .o_clipped   (o_clipped),
    .pready      (pready)
);
